/* sv/d96rnd_pkg.sv */
// Package for the decimal96 round-to-integer core: word widths, action codes,
// flags word layout and the pipeline stage record. No dependencies.
`default_nettype none
package d96rnd_pkg;

  localparam int WORD_W         = 32;
  localparam int ACT_W          = 2;
  localparam int MANT_W         = 3 * WORD_W;
  localparam int MANT_WORDS_DEF = 3;
  localparam int SCALE_W        = 5;
  localparam int DIGIT_W        = 4;

  localparam logic [ACT_W-1:0] ACT_TRUNC = 2'd0;
  localparam logic [ACT_W-1:0] ACT_FLOOR = 2'd1;
  localparam logic [ACT_W-1:0] ACT_ROUND = 2'd2;

  localparam logic [WORD_W-1:0] SIGN_BIT    = 32'h8000_0000;
  localparam logic [WORD_W-1:0] FLAGS_ZERO  = 32'h0000_0000;
  localparam logic [WORD_W-1:0] FLAGS_LEGAL = 32'h80FF_0000;
  localparam int                SCALE_LSB   = 16;
  localparam logic [7:0]        SCALE_MAX   = 8'd28;
  localparam int                SCALE_STEPS = 28;

  localparam logic [DIGIT_W-1:0] HALF_DIGIT = 4'd5;

  // x / 10 = (x * RECIP_10) >> RECIP_SH, exact for x below 10 * 2^16
  localparam int                CHUNK_W  = 16;
  localparam int                CUR_W    = CHUNK_W + DIGIT_W;
  localparam logic [CUR_W-1:0]  RECIP_10 = 20'd838861;
  localparam int                RECIP_SH = 23;

  typedef struct packed {
    logic                  err;
    logic [ACT_W-1:0]      act;
    logic                  sign;
    logic [SCALE_W-1:0]    scale;
    logic [DIGIT_W-1:0]    rem;
    logic [DIGIT_W-1:0]    last_rem;
    logic                  any_rem;
    logic                  only_last;
    logic [MANT_W-1:0]     mant;
  } stg_t;

endpackage
`default_nettype wire

/* sv/d96rnd_ifs.sv */
// Valid/ready channel interfaces for the decimal96 round-to-integer core.
// Depends on d96rnd_pkg for word widths.
`default_nettype none
interface d96rnd_in_if import d96rnd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [WORD_W-1:0] mant_low;
  logic [WORD_W-1:0] mant_mid;
  logic [WORD_W-1:0] mant_high;
  logic [WORD_W-1:0] flags_word;

  modport source (output valid, action, mant_low, mant_mid, mant_high, flags_word,
                  input ready);
  modport sink   (input valid, action, mant_low, mant_mid, mant_high, flags_word,
                  output ready);
endinterface

interface d96rnd_out_if import d96rnd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] res_low;
  logic [WORD_W-1:0] res_mid;
  logic [WORD_W-1:0] res_high;
  logic [WORD_W-1:0] res_flags;
  logic              error;

  modport source (output valid, res_low, res_mid, res_high, res_flags, error,
                  input ready);
  modport sink   (input valid, res_low, res_mid, res_high, res_flags, error,
                  output ready);
endinterface
`default_nettype wire

/* sv/decimal96_round_to_integer_core.sv */
// Decimal96 round-to-integer core: truncate, floor or round-half-even to scale 0.
// Depends on d96rnd_pkg and the channel interfaces in d96rnd_ifs.
//
// Accepts one word per cycle while the pipe is not stalled and returns one
// result word per input word, in order. Each divide-by-ten runs as 2 * W
// sixteen-bit reciprocal steps, one per pipeline stage, W being the arithmetic
// word count (MANT_WORDS capped at 3), and all 28 possible scale steps are laid
// out in the pipe. The whole pipe stalls together when the output word is not
// taken. Invalid flags give error = 1 with all result fields zero.
`default_nettype none
module decimal96_round_to_integer_core import d96rnd_pkg::*; #(
  parameter int MANT_WORDS = MANT_WORDS_DEF
) (
  input  wire          clk,
  input  wire          rst_n,
  d96rnd_in_if.sink    in_ch,
  d96rnd_out_if.source out_ch
);

  localparam int AWORDS = (MANT_WORDS > 3) ? 3 : ((MANT_WORDS < 1) ? 1 : MANT_WORDS);
  localparam int AW     = AWORDS * WORD_W;
  localparam int CH     = AWORDS * (WORD_W / CHUNK_W);
  localparam int NDIV   = SCALE_STEPS * CH;

  stg_t stg_r   [0:NDIV];
  stg_t stg_nxt [0:NDIV];
  logic [NDIV:0] vld_r;

  logic              out_vld_r;
  logic [WORD_W-1:0] res_low_r, res_mid_r, res_high_r, res_flags_r;
  logic              error_r;
  logic [WORD_W-1:0] res_low_nxt, res_mid_nxt, res_high_nxt, res_flags_nxt;
  logic              error_nxt;
  logic              adv;

  assign adv         = !out_vld_r || out_ch.ready;
  assign in_ch.ready = adv;

  // decode
  logic [7:0] scale8;
  logic       bad;
  assign scale8 = in_ch.flags_word[SCALE_LSB +: 8];
  assign bad    = ((in_ch.flags_word & ~FLAGS_LEGAL) != FLAGS_ZERO) || (scale8 > SCALE_MAX);

  always_comb begin
    stg_nxt[0].err       = bad;
    stg_nxt[0].act       = in_ch.action;
    stg_nxt[0].sign      = in_ch.flags_word[WORD_W-1];
    stg_nxt[0].scale     = bad ? '0 : scale8[SCALE_W-1:0];
    stg_nxt[0].rem       = '0;
    stg_nxt[0].last_rem  = '0;
    stg_nxt[0].any_rem   = 1'b0;
    stg_nxt[0].only_last = 1'b1;
    stg_nxt[0].mant      = {in_ch.mant_high, in_ch.mant_mid, in_ch.mant_low};
  end

  // divide-by-ten chunk stages, most significant chunk first
  for (genvar j = 0; j < NDIV; j++) begin : g_div
    localparam int                 STEP  = j / CH;
    localparam int                 CIDX  = CH - 1 - (j % CH);
    localparam logic [SCALE_W-1:0] STEPV = SCALE_W'(STEP);

    logic [CUR_W-1:0]     cur;
    logic [2*CUR_W-1:0]   prod;
    logic [CHUNK_W-1:0]   q;
    logic [CUR_W-1:0]     q10;
    logic [CUR_W-1:0]     r20;

    always_comb begin
      cur  = {((CIDX == CH - 1) ? {DIGIT_W{1'b0}} : stg_r[j].rem),
              stg_r[j].mant[CIDX*CHUNK_W +: CHUNK_W]};
      prod = {{CUR_W{1'b0}}, cur} * {{CUR_W{1'b0}}, RECIP_10};
      q    = prod[RECIP_SH +: CHUNK_W];
      q10  = ({{DIGIT_W{1'b0}}, q} << 3) + ({{DIGIT_W{1'b0}}, q} << 1);
      r20  = cur - q10;
      stg_nxt[j+1] = stg_r[j];
      if (STEPV < stg_r[j].scale) begin
        stg_nxt[j+1].mant[CIDX*CHUNK_W +: CHUNK_W] = q;
        stg_nxt[j+1].rem = r20[DIGIT_W-1:0];
        if ((CIDX == CH - 1) && (stg_r[j].last_rem != '0)) begin
          stg_nxt[j+1].only_last = 1'b0;
        end
        if (CIDX == 0) begin
          stg_nxt[j+1].last_rem = r20[DIGIT_W-1:0];
          if (r20[DIGIT_W-1:0] != '0) begin
            stg_nxt[j+1].any_rem = 1'b1;
          end
        end
      end
    end
  end

  // rounding and result
  stg_t          fin;
  logic          inc;
  logic [AW-1:0] sum;
  logic [MANT_W-1:0] mant_out;

  always_comb begin
    fin = stg_r[NDIV];
    inc = 1'b0;
    case (fin.act)
      ACT_FLOOR: inc = fin.sign && fin.any_rem;
      ACT_ROUND: begin
        if ((fin.last_rem == HALF_DIGIT) && fin.only_last) begin
          inc = fin.mant[0];
        end else begin
          inc = (fin.last_rem >= HALF_DIGIT);
        end
      end
      default: inc = 1'b0;
    endcase
    sum = fin.mant[AW-1:0] + AW'(inc);
    mant_out = fin.mant;
    mant_out[AW-1:0] = sum;
    if (fin.err) begin
      res_low_nxt   = '0;
      res_mid_nxt   = '0;
      res_high_nxt  = '0;
      res_flags_nxt = FLAGS_ZERO;
      error_nxt     = 1'b1;
    end else begin
      res_low_nxt   = mant_out[0 +: WORD_W];
      res_mid_nxt   = mant_out[WORD_W +: WORD_W];
      res_high_nxt  = mant_out[2*WORD_W +: WORD_W];
      res_flags_nxt = fin.sign ? SIGN_BIT : FLAGS_ZERO;
      error_nxt     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      vld_r     <= {vld_r[NDIV-1:0], in_ch.valid};
      out_vld_r <= vld_r[NDIV];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k <= NDIV; k++) begin
        stg_r[k] <= stg_nxt[k];
      end
      res_low_r   <= res_low_nxt;
      res_mid_r   <= res_mid_nxt;
      res_high_r  <= res_high_nxt;
      res_flags_r <= res_flags_nxt;
      error_r     <= error_nxt;
    end
  end

  assign out_ch.valid     = out_vld_r;
  assign out_ch.res_low   = res_low_r;
  assign out_ch.res_mid   = res_mid_r;
  assign out_ch.res_high  = res_high_r;
  assign out_ch.res_flags = res_flags_r;
  assign out_ch.error     = error_r;

  a_rst_clears: assert property (@(posedge clk) !rst_n |=> !out_ch.valid)
    else $error("output valid after reset");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
      out_ch.valid && out_ch.error |-> out_ch.res_low == '0 && out_ch.res_mid == '0 &&
        out_ch.res_high == '0 && out_ch.res_flags == FLAGS_ZERO)
    else $error("error word carries nonzero result");

  a_flags_sign_only: assert property (@(posedge clk) disable iff (!rst_n)
      out_ch.valid |-> (out_ch.res_flags & ~SIGN_BIT) == FLAGS_ZERO)
    else $error("result flags hold more than the sign");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
      !adv |=> $stable(vld_r) && $stable(stg_r[NDIV]))
    else $error("pipe moved while stalled");

endmodule
`default_nettype wire

/* bench/decimal96_round_to_integer_core_tb.sv */
// Testbench for decimal96_round_to_integer_core: directed and random decimals, each result
// checked against a predictor in the bench, with bursty sender and stalling receiver.
// Depends on d96rnd_pkg, the channel interfaces in d96rnd_ifs and the core itself.
`default_nettype none
module decimal96_round_to_integer_core_tb import d96rnd_pkg::*; ();

  localparam int N_RANDOM    = 1525;
  localparam int IDLE_LIMIT  = 3000;
  localparam int HOLD_CYCLES = 600;
  localparam int DRAIN_WAIT  = 200;

  // unused action code, behaves as truncate
  localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [WORD_W-1:0] mant_low;
    logic [WORD_W-1:0] mant_mid;
    logic [WORD_W-1:0] mant_high;
    logic [WORD_W-1:0] flags_word;
  } decimal_t;

  typedef struct packed {
    logic [WORD_W-1:0] res_low;
    logic [WORD_W-1:0] res_mid;
    logic [WORD_W-1:0] res_high;
    logic [WORD_W-1:0] res_flags;
    logic              error;
  } integer_t;

  typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_PERIODIC, RX_SPARSE} rx_mode_t;

  logic clk;
  logic rst_n;

  d96rnd_in_if  in_ch ();
  d96rnd_out_if out_ch ();

  decimal96_round_to_integer_core u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  decimal_t decimal_q[$];
  integer_t integer_q[$];
  int       total_words;
  int       words_in;
  int       fail_cnt;
  int       idle_cycles;
  logic     in_taken;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic logic [127:0] pow10(input int n);
    logic [127:0] p;
    p = 128'd1;
    for (int i = 0; i < n; i++) p = p * 10;
    return p;
  endfunction

  function automatic integer_t to_integer(input decimal_t d);
    logic [MANT_W-1:0] mag;
    logic [7:0]        scale;
    logic [3:0]        top_digit;
    logic              any_frac;
    logic              only_top;
    integer_t          r;
    r     = '0;
    scale = d.flags_word[SCALE_LSB +: 8];
    if ((d.flags_word & ~FLAGS_LEGAL) != FLAGS_ZERO || scale > SCALE_MAX) begin
      r.error = 1'b1;
      return r;
    end
    mag       = {d.mant_high, d.mant_mid, d.mant_low};
    top_digit = '0;
    any_frac  = 1'b0;
    only_top  = 1'b1;
    for (int s = 0; s < scale; s++) begin
      if (top_digit != 0) only_top = 1'b0;
      top_digit = 4'(mag % 10);
      mag       = mag / 10;
      if (top_digit != 0) any_frac = 1'b1;
    end
    case (d.action)
      ACT_FLOOR: begin
        if (d.flags_word[31] && any_frac) mag = mag + 1;
      end
      ACT_ROUND: begin
        if (top_digit == HALF_DIGIT && only_top) begin
          if (mag[0]) mag = mag + 1;
        end else if (top_digit >= HALF_DIGIT) begin
          mag = mag + 1;
        end
      end
      default: ;
    endcase
    r.res_low   = mag[31:0];
    r.res_mid   = mag[63:32];
    r.res_high  = mag[95:64];
    r.res_flags = d.flags_word & SIGN_BIT;
    return r;
  endfunction

  function automatic logic [WORD_W-1:0] scale_flags(input int scale, input logic neg);
    return (neg ? SIGN_BIT : FLAGS_ZERO) | (WORD_W'(scale) << SCALE_LSB);
  endfunction

  task automatic queue_decimal(input logic [ACT_W-1:0] act, input logic [MANT_W-1:0] mag,
                               input logic [WORD_W-1:0] flags);
    decimal_t d;
    d.action     = act;
    d.mant_low   = mag[31:0];
    d.mant_mid   = mag[63:32];
    d.mant_high  = mag[95:64];
    d.flags_word = flags;
    decimal_q.push_back(d);
  endtask

  function automatic decimal_t random_decimal();
    decimal_t          d;
    logic [127:0]      wide;
    logic [MANT_W-1:0] mag;
    int                scale;
    int                b;
    scale = $urandom_range(0, 28);
    d.action = ($urandom_range(0, 9) == 0) ? ACT_SPARE : ACT_W'($urandom_range(0, 2));
    d.flags_word = scale_flags(scale, 1'($urandom_range(0, 1)));
    case ($urandom_range(0, 5))
      0: mag = {$urandom, $urandom, $urandom};
      1: mag = {$urandom, $urandom, $urandom} >> $urandom_range(0, 95);
      2, 3: begin
        // exact half, or one either side of it
        wide = (128'($urandom >> $urandom_range(0, 31)) * 10 + 5)
               * pow10(scale > 0 ? scale - 1 : 0);
        if ($urandom_range(0, 2) == 0) wide = wide + 1;
        else if ($urandom_range(0, 1) == 0) wide = wide - 1;
        mag = wide[MANT_W-1:0];
      end
      4: begin
        wide = 128'($urandom_range(0, 1000)) * pow10(scale);
        mag  = wide[MANT_W-1:0];
      end
      default: mag = 96'($urandom_range(0, 99999));
    endcase
    d.mant_low  = mag[31:0];
    d.mant_mid  = mag[63:32];
    d.mant_high = mag[95:64];
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 2))
        0: d.flags_word = $urandom;
        1: d.flags_word[SCALE_LSB +: 8] = 8'($urandom_range(29, 255));
        default: begin
          b = $urandom_range(0, 22);
          d.flags_word[b < 16 ? b : b + 8] = 1'b1;
        end
      endcase
    end
    return d;
  endfunction

  task automatic check_field(input string name, input logic [WORD_W-1:0] want,
                             input logic [WORD_W-1:0] got);
    if (want !== got) begin
      fail_cnt++;
      $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
    end
  endtask

  // sender: bursts of random length separated by random gaps
  int burst_left;
  int gap_left;

  always @(negedge clk) begin
    decimal_t d;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!(in_ch.valid && !in_taken)) begin
      if (gap_left > 0 || decimal_q.size() == 0) begin
        in_ch.valid <= 1'b0;
        if (gap_left > 0) gap_left--;
      end else begin
        d = decimal_q.pop_front();
        in_ch.valid      <= 1'b1;
        in_ch.action     <= d.action;
        in_ch.mant_low   <= d.mant_low;
        in_ch.mant_mid   <= d.mant_mid;
        in_ch.mant_high  <= d.mant_high;
        in_ch.flags_word <= d.flags_word;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 60);
          gap_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 30)
                                                   : $urandom_range(0, 2);
        end else begin
          burst_left--;
        end
      end
    end
  end

  // receiver: stall pattern of its own, plus long hold-offs to fill the pipe
  rx_mode_t rx_mode;
  int       rx_cycle;
  int       rx_period;
  int       hold_left;
  int       holds_done;

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      rx_cycle++;
      if (rx_cycle % 200 == 0) begin
        rx_mode   = rx_mode_t'($urandom_range(0, 3));
        rx_period = $urandom_range(2, 7);
      end
      if (hold_left == 0 && holds_done < 2 && words_in >= 300 + 700 * holds_done) begin
        hold_left = HOLD_CYCLES;
        holds_done++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_ALWAYS:   out_ch.ready <= 1'b1;
          RX_RANDOM:   out_ch.ready <= ($urandom_range(0, 99) < 60);
          RX_PERIODIC: out_ch.ready <= (rx_cycle % rx_period != 0);
          default:     out_ch.ready <= ($urandom_range(0, 99) < 20);
        endcase
      end
    end
  end

  // monitor, predictor hook and watchdog
  always @(posedge clk) begin
    decimal_t d;
    integer_t want;
    integer_t got;
    in_taken <= in_ch.valid && in_ch.ready;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        d.action     = in_ch.action;
        d.mant_low   = in_ch.mant_low;
        d.mant_mid   = in_ch.mant_mid;
        d.mant_high  = in_ch.mant_high;
        d.flags_word = in_ch.flags_word;
        integer_q.push_back(to_integer(d));
        words_in++;
      end
      if (out_ch.valid && out_ch.ready) begin
        got.res_low   = out_ch.res_low;
        got.res_mid   = out_ch.res_mid;
        got.res_high  = out_ch.res_high;
        got.res_flags = out_ch.res_flags;
        got.error     = out_ch.error;
        if (integer_q.size() == 0) begin
          fail_cnt++;
          $display("%0t: unexpected result word: expected none, got %h", $time, got);
        end else begin
          want = integer_q.pop_front();
          check_field("res_low", want.res_low, got.res_low);
          check_field("res_mid", want.res_mid, got.res_mid);
          check_field("res_high", want.res_high, got.res_high);
          check_field("res_flags", want.res_flags, got.res_flags);
          check_field("error", 32'(want.error), 32'(got.error));
        end
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    logic [MANT_W-1:0] all_ones;
    all_ones = '1;
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.action     = '0;
    in_ch.mant_low   = '0;
    in_ch.mant_mid   = '0;
    in_ch.mant_high  = '0;
    in_ch.flags_word = '0;
    out_ch.ready     = 1'b0;
    in_taken         = 1'b0;
    rx_mode          = RX_ALWAYS;
    rx_period        = 3;

    queue_decimal(ACT_TRUNC, '0, scale_flags(0, 1'b0));
    queue_decimal(ACT_ROUND, all_ones, scale_flags(0, 1'b0));
    queue_decimal(ACT_FLOOR, all_ones, scale_flags(0, 1'b1));
    queue_decimal(ACT_TRUNC, all_ones, scale_flags(28, 1'b0));
    queue_decimal(ACT_FLOOR, all_ones, scale_flags(28, 1'b1));
    queue_decimal(ACT_ROUND, all_ones, scale_flags(28, 1'b0));
    queue_decimal(ACT_ROUND, 96'd25, scale_flags(1, 1'b0));
    queue_decimal(ACT_ROUND, 96'd35, scale_flags(1, 1'b0));
    queue_decimal(ACT_ROUND, 96'd15, scale_flags(1, 1'b1));
    queue_decimal(ACT_ROUND, 96'd2501, scale_flags(3, 1'b0));
    queue_decimal(ACT_ROUND, MANT_W'(pow10(27) * 5), scale_flags(28, 1'b0));
    queue_decimal(ACT_ROUND, MANT_W'(pow10(27) * 15), scale_flags(28, 1'b1));
    queue_decimal(ACT_FLOOR, 96'd25, scale_flags(1, 1'b1));
    queue_decimal(ACT_FLOOR, 96'd25, scale_flags(1, 1'b0));
    queue_decimal(ACT_FLOOR, 96'd300, scale_flags(2, 1'b1));
    queue_decimal(ACT_TRUNC, 96'd29, scale_flags(1, 1'b1));
    queue_decimal(ACT_SPARE, 96'd29, scale_flags(1, 1'b0));
    queue_decimal(ACT_ROUND, '0, scale_flags(28, 1'b1));
    // invalid flags words
    queue_decimal(ACT_TRUNC, 96'd1234, scale_flags(29, 1'b0));
    queue_decimal(ACT_FLOOR, all_ones, scale_flags(255, 1'b1));
    queue_decimal(ACT_ROUND, 96'd77, 32'h0000_0001);
    queue_decimal(ACT_TRUNC, 96'd77, 32'h0100_0000);
    queue_decimal(ACT_ROUND, all_ones, 32'hFFFF_FFFF);
    queue_decimal(ACT_FLOOR, 96'd5, scale_flags(1, 1'b1) | 32'h0000_8000);
    for (int i = 0; i < N_RANDOM; i++) decimal_q.push_back(random_decimal());
    total_words = decimal_q.size();

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    wait (words_in == total_words);
    wait (integer_q.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_cnt == 0 && integer_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* decimal96_round_to_integer_core.f */
sv/d96rnd_pkg.sv
sv/d96rnd_ifs.sv
sv/decimal96_round_to_integer_core.sv
bench/decimal96_round_to_integer_core_tb.sv
